// File: rtl/dpfa_pkg.sv
// ----------------------------------------------------------------------------
// dpfa_pkg
// Shared types and codes of the demand paging frame allocator: item kinds,
// configuration register indexes, and the input and result words.
// ----------------------------------------------------------------------------
package dpfa_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_ACCESS  = 2'd1,
    KIND_INSPECT = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT  = 2'd0,
    REG_PAGE_COUNT   = 2'd1,
    REG_TABLE_FRAMES = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [8:0] FRAME_COUNT_RST  = 9'd256;
  localparam logic [6:0] PAGE_COUNT_RST   = 7'd64;
  localparam logic [6:0] TABLE_FRAMES_RST = 7'd8;

  // Counter limits
  localparam logic [7:0]  ALLOC_MAX = 8'd255;
  localparam logic [6:0]  FAULT_MAX = 7'd127;
  localparam logic [15:0] REFS_MAX  = 16'd65535;

  // Input word
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  process_slot;
    logic [5:0]  page_number;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [7:0]  frame_number;
    logic        entry_valid;
    logic        was_fault;
    logic [7:0]  entry_refs;
    logic        rejected;
    logic        memory_exhausted;
    logic [7:0]  allocated_frames;
    logic [6:0]  page_faults;
    logic [15:0] reference_total;
  } out_item_t;

endpackage

// File: rtl/dpfa_ram.sv
// ----------------------------------------------------------------------------
// dpfa_ram
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module dpfa_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/demand_paging_frame_allocator_top.sv
// Path: an accepted item is held in the input register, where its entry table
// read lands with it; its update then lands in the result register once that
// register can load (it is empty or its word is taken).
// Throughput: one item per cycle; a stalled result word holds the input
// register and stalls the input. A write to the entry being read is forwarded.
// Reset: synchronous, active low; clears counters, page valid bits and the
// out-of-memory flag and restores the configuration defaults.
// ----------------------------------------------------------------------------
// demand_paging_frame_allocator_top
// Per-process single-level page tables backed by a bump frame allocator.
// ----------------------------------------------------------------------------
module demand_paging_frame_allocator_top
  import dpfa_pkg::*;
#(
  parameter int PROCESS_SLOTS = 16,
  parameter int PAGE_SLOTS    = 64,
  parameter int FRAME_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int PAGE_W  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int DEPTH   = PROCESS_SLOTS * PAGE_SLOTS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FU_W    = FRAME_BITS + 1;
  localparam int CW      = (FU_W > 9) ? FU_W : 9;
  localparam int FX_W    = (FRAME_BITS > 8) ? FRAME_BITS : 8;
  localparam int ENT_W   = FRAME_BITS + 8;

  // Configuration registers
  logic [8:0] frame_count_r;
  logic [6:0] page_count_r;
  logic [6:0] table_frames_r;

  // Allocator and per-process state
  logic [FU_W-1:0]       frames_used_r, frames_used_nxt;
  logic                  oom_r, oom_nxt;
  logic [PAGE_SLOTS-1:0] valid_r [PROCESS_SLOTS];
  logic [7:0]            alloc_r [PROCESS_SLOTS];
  logic [6:0]            fault_r [PROCESS_SLOTS];
  logic [15:0]           refs_r  [PROCESS_SLOTS];

  // Pipeline registers
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  // Last entry write, for forwarding over the RAM read
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [ENT_W-1:0]  fwd_data_r;

  // Handshakes
  logic in_accept, out_load, s1_fire;
  logic [ADDR_W-1:0] in_addr;

  assign out_load  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry table address of an incoming item
  assign in_addr = ADDR_W'(int'(SLOT_W'(in_data.process_slot)) * PAGE_SLOTS
                           + int'(PAGE_W'(in_data.page_number)));

  // Entry table: frame number over reference count
  logic             ram_wr_en;
  logic [ENT_W-1:0] ram_wr_data;
  logic [ENT_W-1:0] ram_rd_data;

  dpfa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (s1_fire && ram_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (ram_wr_data),
    .rd_en   (in_accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd_data)
  );

  // Update logic of the item in the first stage
  logic              slot_ok, page_ok;
  logic [SLOT_W-1:0] s_idx;
  logic [PAGE_W-1:0] p_idx;
  logic [CW-1:0]     fu_ext, cap, limit, avail, tf_ext, take;
  logic [ENT_W-1:0]  ent;
  logic [FRAME_BITS-1:0] ent_frame, new_frame;
  logic [7:0]        ent_refs, new_refs;
  logic              cur_valid, new_valid, fault, rej;
  logic              row_clear, bit_set;
  logic [7:0]        alloc_new;
  logic [6:0]        fault_new;
  logic [15:0]       refs_new;
  logic [FX_W-1:0]   frame_ext;

  always_comb begin
    slot_ok   = 32'(s1_item_r.process_slot) < PROCESS_SLOTS;
    page_ok   = (7'(s1_item_r.page_number) < page_count_r)
                && (32'(s1_item_r.page_number) < PAGE_SLOTS);
    s_idx     = SLOT_W'(s1_item_r.process_slot);
    p_idx     = PAGE_W'(s1_item_r.page_number);

    // usable frame limit and what is left of it
    fu_ext    = CW'(frames_used_r);
    cap       = CW'(1) << FRAME_BITS;
    limit     = (CW'(frame_count_r) < cap) ? CW'(frame_count_r) : cap;
    avail     = (limit > fu_ext) ? (limit - fu_ext) : '0;
    tf_ext    = CW'(table_frames_r);
    take      = (tf_ext < avail) ? tf_ext : avail;

    // current entry, newest write first
    ent       = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rd_data;
    ent_frame = ent[ENT_W-1:8];
    ent_refs  = ent[7:0];
    cur_valid = slot_ok && page_ok && valid_r[s_idx][p_idx];

    frames_used_nxt = frames_used_r;
    oom_nxt   = oom_r;
    new_frame = ent_frame;
    new_refs  = ent_refs;
    new_valid = cur_valid;
    fault     = 1'b0;
    rej       = 1'b0;
    row_clear = 1'b0;
    bit_set   = 1'b0;
    ram_wr_en = 1'b0;
    alloc_new = slot_ok ? alloc_r[s_idx] : '0;
    fault_new = slot_ok ? fault_r[s_idx] : '0;
    refs_new  = slot_ok ? refs_r[s_idx]  : '0;

    if (!slot_ok) begin
      rej = 1'b1;
    end else begin
      case (s1_item_r.kind)
        KIND_CREATE: begin
          // clear the slot and charge its page table
          row_clear       = 1'b1;
          frames_used_nxt = FU_W'(fu_ext + take);
          if (tf_ext > avail) begin
            oom_nxt = 1'b1;
          end
          alloc_new = 8'(table_frames_r);
          fault_new = '0;
          refs_new  = '0;
          new_valid = 1'b0;
        end
        KIND_ACCESS: begin
          if (!page_ok || oom_r) begin
            rej = 1'b1;
          end else if (cur_valid) begin
            new_refs  = ent_refs + 8'd1;
            ram_wr_en = 1'b1;
            refs_new  = (refs_new == REFS_MAX) ? refs_new : refs_new + 16'd1;
          end else if (fu_ext >= limit) begin
            oom_nxt = 1'b1;
            rej     = 1'b1;
          end else begin
            // map the page to the next free frame
            new_frame       = frames_used_r[FRAME_BITS-1:0];
            new_refs        = 8'd1;
            new_valid       = 1'b1;
            bit_set         = 1'b1;
            ram_wr_en       = 1'b1;
            fault           = 1'b1;
            frames_used_nxt = frames_used_r + FU_W'(1);
            alloc_new = (alloc_new == ALLOC_MAX) ? alloc_new : alloc_new + 8'd1;
            fault_new = (fault_new == FAULT_MAX) ? fault_new : fault_new + 7'd1;
            refs_new  = (refs_new == REFS_MAX) ? refs_new : refs_new + 16'd1;
          end
        end
        KIND_INSPECT: begin
          if (!page_ok) begin
            rej = 1'b1;
          end
        end
        default: begin
          new_valid = 1'b0;
        end
      endcase
    end

    ram_wr_data = {new_frame, new_refs};
    frame_ext   = FX_W'(new_frame);

    out_data_nxt.frame_number     = new_valid ? frame_ext[7:0] : '0;
    out_data_nxt.entry_valid      = new_valid;
    out_data_nxt.was_fault        = fault;
    out_data_nxt.entry_refs       = new_valid ? new_refs : '0;
    out_data_nxt.rejected         = rej;
    out_data_nxt.memory_exhausted = oom_nxt;
    out_data_nxt.allocated_frames = alloc_new;
    out_data_nxt.page_faults      = fault_new;
    out_data_nxt.reference_total  = refs_new;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= FRAME_COUNT_RST;
      page_count_r   <= PAGE_COUNT_RST;
      table_frames_r <= TABLE_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_COUNT:  frame_count_r  <= cfg_data;
        REG_PAGE_COUNT:   page_count_r   <= cfg_data[6:0];
        REG_TABLE_FRAMES: table_frames_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire && ram_wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
      s1_addr_r <= in_addr;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
    if (s1_fire && ram_wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= ram_wr_data;
    end
  end

  // Commit allocator and per-process state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_used_r <= '0;
      oom_r         <= 1'b0;
      for (int i = 0; i < PROCESS_SLOTS; i++) begin
        valid_r[i] <= '0;
        alloc_r[i] <= '0;
        fault_r[i] <= '0;
        refs_r[i]  <= '0;
      end
    end else if (s1_fire) begin
      frames_used_r <= frames_used_nxt;
      oom_r         <= oom_nxt;
      if (slot_ok) begin
        alloc_r[s_idx] <= alloc_new;
        fault_r[s_idx] <= fault_new;
        refs_r[s_idx]  <= refs_new;
        if (row_clear) begin
          valid_r[s_idx] <= '0;
        end else if (bit_set) begin
          valid_r[s_idx][p_idx] <= 1'b1;
        end
      end
    end
  end

  // Checks
  a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frames_used_r) <= (1 << FRAME_BITS))
    else $error("frames_used exceeds the frame space");

  a_oom_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    oom_r |=> oom_r)
    else $error("out-of-memory flag cleared without reset");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("committed item produced no result");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty first stage");

endmodule
